// ----- src/rmpf_pkg.sv -----
// Shared constants and types for the RGB565 monochrome page framebuffer.
// Used by every module in src; depends on nothing else.
package rmpf_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_BYTES);

    localparam logic [7:0] LUMA_RESET = 8'd90;
    localparam logic [4:0] R_MASK     = 5'h1F;
    localparam logic [5:0] G_MASK     = 6'h3F;
    localparam logic [7:0] FILL_ON    = 8'hFF;
    localparam logic [7:0] FILL_OFF   = 8'h00;

    localparam logic [1:0] OP_BLIT  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Result of placing one blit pixel.
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
    } pos_res_t;

endpackage

// ----- src/rgb565_mono_page_framebuffer_unit.sv -----
// Top level of the RGB565 monochrome page framebuffer.
// Depends on rmpf_pkg, rmpf_luma, rmpf_pos and rmpf_store.

// The block holds a 1-bit-per-pixel image in 8-pixel vertical pages and is
// driven one beat at a time: in_stall is high whenever the sequencer is busy.
// A blit beat that lands on screen is accepted with a store read, then the
// modified byte is written back; an off-screen, beyond-window or zero-window
// blit and the unused op are accepted without leaving idle. A read beat reads
// the store and loads the result register once it is free; the result then
// waits for out_stall to drop while new blit and clear beats are still taken.
// A clear beat sweeps the store one byte per cycle. After reset the same sweep
// writes zeros over the whole store before the first beat is taken; threshold
// writes are accepted throughout.
module rgb565_mono_page_framebuffer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic               first_pixel,
    input  logic signed [15:0] origin_x,
    input  logic signed [15:0] origin_y,
    input  logic [15:0]        win_width,
    input  logic [15:0]        win_height,
    input  logic [15:0]        color,
    input  logic [9:0]         byte_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         fb_byte
);

    localparam logic [rmpf_pkg::ADDR_W-1:0] LAST_ADDR =
        rmpf_pkg::ADDR_W'(rmpf_pkg::STORE_BYTES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BLIT_WR,
        ST_READ
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [7:0]                  threshold_reg;
    logic [7:0]                  threshold_next;
    logic [rmpf_pkg::ADDR_W-1:0] addr_reg;
    logic [rmpf_pkg::ADDR_W-1:0] addr_next;
    logic [7:0]                  fill_reg;
    logic [7:0]                  fill_next;
    logic [7:0]                  mask_reg;
    logic [7:0]                  mask_next;
    logic                        pix_on_reg;
    logic                        pix_on_next;
    logic                        rd_zero_reg;
    logic                        rd_zero_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  fb_byte_reg;
    logic [7:0]                  fb_byte_next;

    logic                        accept;
    logic                        blit_go;
    logic                        color_on;
    rmpf_pkg::pos_res_t          pos;
    logic                        wr_en;
    logic [rmpf_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                  wr_data;
    logic                        rd_en;
    logic [rmpf_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;
    logic                        out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign blit_go   = accept && (op == rmpf_pkg::OP_BLIT);
    assign out_valid = out_valid_reg;
    assign fb_byte   = fb_byte_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    rmpf_luma u_luma (
        .color     (color),
        .threshold (threshold_reg),
        .on        (color_on)
    );

    rmpf_pos u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (blit_go),
        .first_pixel (first_pixel),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .win_width   (win_width),
        .win_height  (win_height),
        .res         (pos)
    );

    rmpf_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        threshold_next = cfg_wr_en ? cfg_wr_data : threshold_reg;
        addr_next      = addr_reg;
        fill_next      = fill_reg;
        mask_next      = mask_reg;
        pix_on_next    = pix_on_reg;
        rd_zero_next   = rd_zero_reg;
        out_valid_next = out_valid_reg && out_stall;
        fb_byte_next   = fb_byte_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = fill_reg;
        rd_en          = 1'b0;
        rd_addr        = pos.addr;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        rmpf_pkg::OP_BLIT:
                        begin
                            if (pos.hit)
                            begin
                                rd_en       = 1'b1;
                                addr_next   = pos.addr;
                                mask_next   = 8'd1 << pos.bit_sel;
                                pix_on_next = color_on;
                                state_next  = ST_BLIT_WR;
                            end
                        end
                        rmpf_pkg::OP_CLEAR:
                        begin
                            fill_next  = color_on ? rmpf_pkg::FILL_ON : rmpf_pkg::FILL_OFF;
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        rmpf_pkg::OP_READ:
                        begin
                            // Addresses past the store answer zero.
                            rd_zero_next = 32'(byte_index) >= rmpf_pkg::STORE_BYTES;
                            rd_en        = 1'b1;
                            rd_addr      = rmpf_pkg::ADDR_W'(byte_index);
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BLIT_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = pix_on_reg ? (rd_data | mask_reg) : (rd_data & ~mask_reg);
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fb_byte_next   = rd_zero_reg ? 8'd0 : rd_data;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            threshold_reg <= rmpf_pkg::LUMA_RESET;
            addr_reg      <= '0;
            fill_reg      <= rmpf_pkg::FILL_OFF;
            out_valid_reg <= 1'b0;
            mask_reg      <= 8'd0;
            pix_on_reg    <= 1'b0;
            rd_zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            threshold_reg <= threshold_next;
            addr_reg      <= addr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            pix_on_reg    <= pix_on_next;
            rd_zero_reg   <= rd_zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fb_byte_reg <= fb_byte_next;
    end

endmodule

// ----- src/rmpf_luma.sv -----
// Luma threshold unit: turns an RGB565 color into one pixel bit.
// Depends on rmpf_pkg.
module rmpf_luma (
    input  logic [15:0] color,
    input  logic [7:0]  threshold,
    output logic        on
);

    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [8:0] luma;

    always_comb
    begin
        r    = color[15:11] & rmpf_pkg::R_MASK;
        g    = color[10:5] & rmpf_pkg::G_MASK;
        b    = color[4:0] & rmpf_pkg::R_MASK;
        luma = {3'b000, r, 1'b0} + {3'b000, g} + {3'b000, b, 1'b0};
        on   = luma > {1'b0, threshold};
    end

endmodule

// ----- src/rmpf_pos.sv -----
// Blit position unit: window column and row counters and the store address
// of the current pixel. Depends on rmpf_pkg.
module rmpf_pos (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic                 first_pixel,
    input  logic signed [15:0]   origin_x,
    input  logic signed [15:0]   origin_y,
    input  logic [15:0]          win_width,
    input  logic [15:0]          win_height,
    output rmpf_pkg::pos_res_t   res
);

    localparam logic signed [17:0] X_LIMIT = 18'(rmpf_pkg::DISPLAY_WIDTH);
    localparam logic signed [17:0] Y_LIMIT = 18'(rmpf_pkg::DISPLAY_HEIGHT);

    logic [15:0]        col_count_reg;
    logic [15:0]        col_count_next;
    logic [15:0]        row_count_reg;
    logic [15:0]        row_count_next;
    logic [15:0]        col_eff;
    logic [15:0]        row_eff;
    logic [16:0]        col_inc;
    logic               zero_win;
    logic               in_window;
    logic               on_screen;
    logic signed [17:0] x;
    logic signed [17:0] y;

    always_comb
    begin
        zero_win  = (win_width == 16'd0) || (win_height == 16'd0);
        col_eff   = first_pixel ? 16'd0 : col_count_reg;
        row_eff   = first_pixel ? 16'd0 : row_count_reg;
        in_window = (col_eff < win_width) && (row_eff < win_height);
        x = $signed({{2{origin_x[15]}}, origin_x}) + $signed({2'b00, col_eff});
        y = $signed({{2{origin_y[15]}}, origin_y}) + $signed({2'b00, row_eff});
        on_screen = !x[17] && (x < X_LIMIT) && !y[17] && (y < Y_LIMIT);
        col_inc   = {1'b0, col_eff} + 17'd1;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (go && !zero_win)
        begin
            col_count_next = col_eff;
            row_count_next = row_eff;
            if (in_window)
            begin
                if (col_inc >= {1'b0, win_width})
                begin
                    col_count_next = 16'd0;
                    row_count_next = row_eff + 16'd1;
                end
                else
                begin
                    col_count_next = col_inc[15:0];
                end
            end
        end

        res.hit     = go && !zero_win && in_window && on_screen;
        res.addr    = rmpf_pkg::ADDR_W'(32'(y[7:3]) * rmpf_pkg::DISPLAY_WIDTH
                      + 32'(x[8:0]));
        res.bit_sel = y[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= 16'd0;
            row_count_reg <= 16'd0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

// ----- src/rmpf_store.sv -----
// Frame store: one byte per 8-pixel page column, one write and one
// registered read per cycle. Depends on rmpf_pkg.
module rmpf_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [rmpf_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [rmpf_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data
);

    logic [7:0] mem [rmpf_pkg::STORE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
